// File: src/tms_pkg.sv
// tone melody sequencer package: request and register codes, melody rom
// functions and the click constants
// no dependencies

package tms_pkg;

    // request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_PLAY   = 2'd1,
        REQ_CLICK  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SOUND_ENABLE = 2'd0,
        CFG_CLICK_ENABLE = 2'd1,
        CFG_QUIET_START  = 2'd2,
        CFG_QUIET_END    = 2'd3
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned HZ_W       = 12;
    localparam int unsigned MS_W       = 8;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned SEL_W      = 3;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned CLICK_W    = 4;

    localparam logic [SEL_W-1:0]   NUM_MELODIES = 3'd5;
    localparam logic [CLICK_W-1:0] CLICK_TICKS  = 4'd8;
    localparam logic [HZ_W-1:0]    CLICK_HZ     = 12'd4000;
    localparam logic [MS_W-1:0]    MS_MAX       = 8'd255;

    typedef logic [HZ_W-1:0]   hz_t;
    typedef logic [MS_W-1:0]   ms_t;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [SEL_W-1:0]  sel_t;

    // step frequency, 0 is a pause
    function automatic hz_t rom_hz(input sel_t sel, input step_t step);
        hz_t hz;
        hz = '0;
        case ({sel, step})
            {3'd0, 3'd0}: hz = 12'd1047;
            {3'd0, 3'd2}: hz = 12'd1319;
            {3'd0, 3'd4}: hz = 12'd1568;
            {3'd0, 3'd6}: hz = 12'd2093;
            {3'd1, 3'd0}: hz = 12'd880;
            {3'd1, 3'd2}: hz = 12'd880;
            {3'd1, 3'd4}: hz = 12'd880;
            {3'd2, 3'd0}: hz = 12'd1047;
            {3'd2, 3'd2}: hz = 12'd1568;
            {3'd3, 3'd0}: hz = 12'd4000;
            {3'd4, 3'd0}: hz = 12'd784;
            {3'd4, 3'd2}: hz = 12'd659;
            {3'd4, 3'd4}: hz = 12'd523;
            default:      hz = '0;
        endcase
        return hz;
    endfunction

    // step duration in milliseconds
    function automatic ms_t rom_ms(input sel_t sel, input step_t step);
        ms_t ms;
        ms = '0;
        case ({sel, step})
            {3'd0, 3'd0}: ms = 8'd120;
            {3'd0, 3'd1}: ms = 8'd40;
            {3'd0, 3'd2}: ms = 8'd120;
            {3'd0, 3'd3}: ms = 8'd40;
            {3'd0, 3'd4}: ms = 8'd120;
            {3'd0, 3'd5}: ms = 8'd40;
            {3'd0, 3'd6}: ms = 8'd250;
            {3'd1, 3'd0}: ms = 8'd100;
            {3'd1, 3'd1}: ms = 8'd80;
            {3'd1, 3'd2}: ms = 8'd100;
            {3'd1, 3'd3}: ms = 8'd80;
            {3'd1, 3'd4}: ms = 8'd100;
            {3'd2, 3'd0}: ms = 8'd80;
            {3'd2, 3'd1}: ms = 8'd40;
            {3'd2, 3'd2}: ms = 8'd120;
            {3'd3, 3'd0}: ms = 8'd8;
            {3'd4, 3'd0}: ms = 8'd150;
            {3'd4, 3'd1}: ms = 8'd50;
            {3'd4, 3'd2}: ms = 8'd150;
            {3'd4, 3'd3}: ms = 8'd50;
            {3'd4, 3'd4}: ms = 8'd200;
            default:      ms = '0;
        endcase
        return ms;
    endfunction

    // number of steps in each melody
    function automatic step_t rom_len(input sel_t sel);
        step_t len;
        len = '0;
        case (sel)
            3'd0:    len = 3'd7;
            3'd1:    len = 3'd5;
            3'd2:    len = 3'd3;
            3'd3:    len = 3'd1;
            3'd4:    len = 3'd5;
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: src/tms_in_if.sv
// request channel of the tone melody sequencer: valid, ready and request fields
// depends on tms_pkg

interface tms_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [2:0]                    event_code;
    logic [tms_pkg::HOUR_W-1:0]    hour_now;
    logic                          hour_known;

    modport source (output valid, req_type, event_code, hour_now, hour_known, input ready);
    modport sink   (input valid, req_type, event_code, hour_now, hour_known, output ready);
endinterface

// File: src/tms_out_if.sv
// result channel of the tone melody sequencer: valid, ready and status fields
// depends on tms_pkg

interface tms_out_if;
    logic                        valid;
    logic                        ready;
    logic [tms_pkg::HZ_W-1:0]    tone_hz;
    logic                        melody_active;
    logic                        started;
    logic                        click_busy;

    modport source (output valid, tone_hz, melody_active, started, click_busy, input ready);
    modport sink   (input valid, tone_hz, melody_active, started, click_busy, output ready);
endinterface

// File: src/tone_melody_sequencer.sv
// Tone melody sequencer: takes one request item (tick, play, click or unused) per clock
// cycle and returns one status item for each, in the cycle after acceptance. The
// whole state update (rom lookup, duration compare, quiet window check) sits
// between the sequencer state registers and the result register, so the
// sustained rate is one item per cycle; the result register only stalls intake
// while a result is held and the sink is not ready.
// depends on tms_pkg, tms_in_if, tms_out_if

module tone_melody_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    tms_in_if.sink                            in_ch,
    tms_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  tms_pkg::cfg_idx_t                 cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tms_pkg::*;

    // configuration registers
    logic                  sound_enable_reg;
    logic                  click_enable_reg;
    logic [HOUR_W-1:0]     quiet_start_reg;
    logic [HOUR_W-1:0]     quiet_end_reg;

    // sequencer state
    sel_t                  sel_reg, sel_next;
    step_t                 step_reg, step_next;
    ms_t                   elapsed_reg, elapsed_next;
    logic                  active_reg, active_next;
    logic [CLICK_W-1:0]    click_reg, click_next;

    // result register
    logic                  out_valid_reg;
    hz_t                   tone_hz_reg, tone_hz_next;
    logic                  active_out_reg;
    logic                  started_reg, started_next;
    logic                  click_busy_reg;

    logic                  in_accept;
    logic                  quiet;
    ms_t                   elapsed_inc;
    step_t                 step_inc;
    req_t                  req;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign req         = req_t'(in_ch.req_type);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg <= 1'b1;
            click_enable_reg <= 1'b1;
            quiet_start_reg  <= '0;
            quiet_end_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOUND_ENABLE: sound_enable_reg <= cfg_data[0];
                CFG_CLICK_ENABLE: click_enable_reg <= cfg_data[0];
                CFG_QUIET_START:  quiet_start_reg  <= cfg_data[HOUR_W-1:0];
                CFG_QUIET_END:    quiet_end_reg    <= cfg_data[HOUR_W-1:0];
            endcase
        end
    end

    // quiet window, may wrap past midnight
    always_comb
    begin
        if (quiet_start_reg == quiet_end_reg || !in_ch.hour_known)
            quiet = 1'b0;
        else if (quiet_start_reg < quiet_end_reg)
            quiet = (in_ch.hour_now >= quiet_start_reg) && (in_ch.hour_now < quiet_end_reg);
        else
            quiet = (in_ch.hour_now >= quiet_start_reg) || (in_ch.hour_now < quiet_end_reg);
    end

    assign elapsed_inc = (elapsed_reg < MS_MAX) ? elapsed_reg + 8'd1 : elapsed_reg;
    assign step_inc    = step_reg + 3'd1;

    // next state for the item at the input
    always_comb
    begin
        sel_next     = sel_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        active_next  = active_reg;
        click_next   = click_reg;
        started_next = 1'b0;
        unique case (req)
            REQ_TICK:
            begin
                if (click_reg != '0)
                begin
                    click_next = click_reg - 4'd1;
                    if (click_reg == 4'd1 && active_reg)
                        elapsed_next = '0;
                end
                else if (active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= rom_ms(sel_reg, step_reg))
                    begin
                        elapsed_next = '0;
                        step_next    = step_inc;
                        if (sel_reg >= NUM_MELODIES || step_inc >= rom_len(sel_reg))
                        begin
                            active_next = 1'b0;
                            step_next   = '0;
                        end
                    end
                end
            end
            REQ_PLAY:
            begin
                if (sound_enable_reg && !quiet && !active_reg && click_reg == '0
                    && in_ch.event_code < NUM_MELODIES)
                begin
                    sel_next     = in_ch.event_code;
                    step_next    = '0;
                    elapsed_next = '0;
                    active_next  = 1'b1;
                    started_next = 1'b1;
                end
            end
            REQ_CLICK:
            begin
                if (sound_enable_reg && click_enable_reg)
                    click_next = CLICK_TICKS;
            end
            REQ_UNUSED:
            begin
                // status only
            end
        endcase
    end

    // tone from the updated state
    always_comb
    begin
        if (click_next != '0)
            tone_hz_next = CLICK_HZ;
        else if (active_next)
            tone_hz_next = rom_hz(sel_next, step_next);
        else
            tone_hz_next = '0;
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= '0;
            step_reg    <= '0;
            elapsed_reg <= '0;
            active_reg  <= 1'b0;
            click_reg   <= '0;
        end
        else if (in_accept)
        begin
            sel_reg     <= sel_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
            active_reg  <= active_next;
            click_reg   <= click_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tone_hz_reg    <= tone_hz_next;
            active_out_reg <= active_next;
            started_reg    <= started_next;
            click_busy_reg <= (click_next != '0);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.tone_hz       = tone_hz_reg;
    assign out_ch.melody_active = active_out_reg;
    assign out_ch.started       = started_reg;
    assign out_ch.click_busy    = click_busy_reg;

    // a started melody is reported active
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && started_reg |-> active_out_reg)
        else $error("started without melody active");

    // click tone overrides everything
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && click_busy_reg |-> tone_hz_reg == CLICK_HZ)
        else $error("click busy without click tone");

    // silence when neither melody nor click
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !click_busy_reg && !active_out_reg |-> tone_hz_reg == '0)
        else $error("tone while idle");

    // playing position stays inside the melody
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (sel_reg < NUM_MELODIES) && (step_reg < rom_len(sel_reg)))
        else $error("step outside melody");

    // idle sequencer rests on step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> step_reg == '0)
        else $error("idle with nonzero step");

endmodule

// File: tb/sv/tone_melody_sequencer_tb.sv
// testbench for tone_melody_sequencer: queue-fed request driver, status monitor
// and an in-bench melody and click predictor checked field by field
// depends on tms_pkg, tms_in_if, tms_out_if and tone_melody_sequencer
`timescale 1ns / 1ps

module tone_melody_sequencer_tb;

    import tms_pkg::*;

    typedef struct {
        req_t         req;
        logic [2:0]   code;
        logic [4:0]   hour;
        logic         known;
    } req_item_t;

    typedef struct {
        hz_t   hz;
        logic  active;
        logic  started;
        logic  busy;
    } status_t;

    // melody table: frequency, duration and length per melody
    localparam int unsigned MEL_COUNT = 5;
    localparam int unsigned MEL_STEPS = 7;
    localparam int unsigned BEEP_HZ = 4000;
    localparam int unsigned BEEP_TICKS = 8;
    localparam int unsigned MEL_HZ [MEL_COUNT][MEL_STEPS] = '{
        '{1047, 0, 1319, 0, 1568, 0, 2093},
        '{880, 0, 880, 0, 880, 0, 0},
        '{1047, 0, 1568, 0, 0, 0, 0},
        '{4000, 0, 0, 0, 0, 0, 0},
        '{784, 0, 659, 0, 523, 0, 0}};
    localparam int unsigned MEL_MS [MEL_COUNT][MEL_STEPS] = '{
        '{120, 40, 120, 40, 120, 40, 250},
        '{100, 80, 100, 80, 100, 0, 0},
        '{80, 40, 120, 0, 0, 0, 0},
        '{8, 0, 0, 0, 0, 0, 0},
        '{150, 50, 150, 50, 200, 0, 0}};
    localparam int unsigned MEL_LEN [MEL_COUNT] = '{7, 5, 3, 1, 5};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tms_in_if  in_ch ();
    tms_out_if out_ch ();

    tone_melody_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state and register copies
    logic       sound_on;
    logic       click_on;
    logic [4:0] quiet_from;
    logic [4:0] quiet_to;
    logic [2:0] mel_sel;
    logic [2:0] mel_step;
    logic [7:0] step_ms;
    logic       playing;
    logic [3:0] click_left;

    req_item_t   req_pending [$];
    status_t     status_due [$];
    int unsigned queued_cnt;
    int unsigned accepted_cnt;
    int unsigned mismatch_cnt;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned phase_no;
    logic        hold_off;
    logic        in_taken;

    always #4 clk = ~clk;

    // advance the predictor by one item and return the status it reports
    function automatic status_t next_status(input req_item_t it);
        status_t     s;
        logic        quiet;
        int unsigned dur;
        s.started = 1'b0;
        case (it.req)
            REQ_TICK:
            begin
                if (click_left != 4'd0)
                begin
                    click_left = click_left - 4'd1;
                    if (click_left == 4'd0 && playing)
                        step_ms = 8'd0;
                end
                else if (playing)
                begin
                    if (step_ms != 8'd255)
                        step_ms = step_ms + 8'd1;
                    dur = (mel_sel < MEL_COUNT && mel_step < MEL_STEPS) ?
                          MEL_MS[mel_sel][mel_step] : 0;
                    if (step_ms >= dur)
                    begin
                        mel_step = mel_step + 3'd1;
                        step_ms  = 8'd0;
                        if (mel_sel >= MEL_COUNT || mel_step >= MEL_LEN[mel_sel])
                        begin
                            playing  = 1'b0;
                            mel_step = 3'd0;
                        end
                    end
                end
            end
            REQ_PLAY:
            begin
                // quiet window, wrapping past midnight when start > end
                if (quiet_from == quiet_to || !it.known)
                    quiet = 1'b0;
                else if (quiet_from < quiet_to)
                    quiet = (it.hour >= quiet_from) && (it.hour < quiet_to);
                else
                    quiet = (it.hour >= quiet_from) || (it.hour < quiet_to);
                if (sound_on && !quiet && !playing && click_left == 4'd0 &&
                    it.code < MEL_COUNT)
                begin
                    mel_sel   = it.code;
                    mel_step  = 3'd0;
                    step_ms   = 8'd0;
                    playing   = 1'b1;
                    s.started = 1'b1;
                end
            end
            REQ_CLICK:
            begin
                if (sound_on && click_on)
                    click_left = 4'(BEEP_TICKS);
            end
            default:
            begin
            end
        endcase
        if (click_left != 4'd0)
            s.hz = 12'(BEEP_HZ);
        else if (playing && mel_sel < MEL_COUNT && mel_step < MEL_STEPS)
            s.hz = 12'(MEL_HZ[mel_sel][mel_step]);
        else
            s.hz = '0;
        s.active = playing;
        s.busy   = (click_left != 4'd0);
        return s;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        mismatch_cnt++;
    endtask

    task automatic push_req(input req_t req, input logic [2:0] code,
                            input logic [4:0] hour, input logic known);
        req_item_t it;
        it.req   = req;
        it.code  = code;
        it.hour  = hour;
        it.known = known;
        req_pending.push_back(it);
        queued_cnt++;
    endtask

    // random request, biased toward ticks so melodies run to their end
    task automatic push_random(input int unsigned count);
        int unsigned r;
        req_t        req;
        logic [2:0]  code;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 72)
                req = REQ_TICK;
            else if (r < 84)
                req = REQ_PLAY;
            else if (r < 94)
                req = REQ_CLICK;
            else
                req = REQ_UNUSED;
            code = ($urandom_range(2) == 0) ? 3'd3 : 3'($urandom_range(7));
            push_req(req, code, 5'($urandom_range(31)), 1'($urandom_range(1)));
        end
    endtask

    // wait until every queued item is in and every status is back
    task automatic drain();
        while (accepted_cnt != queued_cnt || status_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [4:0] val);
        @(negedge clk);
        case (idx)
            CFG_SOUND_ENABLE: sound_on   = val[0];
            CFG_CLICK_ENABLE: click_on   = val[0];
            CFG_QUIET_START:  quiet_from = val;
            CFG_QUIET_END:    quiet_to   = val;
            default:          ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // request driver: next item once the current one is taken
    always @(negedge clk)
    begin : drive_req
        req_item_t nxt;
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = req_pending.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.req_type   <= nxt.req;
                in_ch.event_code <= nxt.code;
                in_ch.hour_now   <= nxt.hour;
                in_ch.hour_known <= nxt.known;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // status receiver ready
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check returned status, then predict for the accepted item
    always @(posedge clk)
    begin : check_status
        status_t   want;
        req_item_t it;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (status_due.size() == 0)
                    report_mismatch("unexpected result tone_hz", out_ch.tone_hz, 0);
                else
                begin
                    want = status_due.pop_front();
                    if (out_ch.tone_hz !== want.hz)
                        report_mismatch("tone_hz", out_ch.tone_hz, want.hz);
                    if (out_ch.melody_active !== want.active)
                        report_mismatch("melody_active", out_ch.melody_active, want.active);
                    if (out_ch.started !== want.started)
                        report_mismatch("started", out_ch.started, want.started);
                    if (out_ch.click_busy !== want.busy)
                        report_mismatch("click_busy", out_ch.click_busy, want.busy);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                it.req   = req_t'(in_ch.req_type);
                it.code  = in_ch.event_code;
                it.hour  = in_ch.hour_now;
                it.known = in_ch.hour_known;
                status_due.push_back(next_status(it));
                accepted_cnt++;
            end
        end
    end

    // long receiver hold-off in the last phase so the block backs up
    initial
    begin
        wait (phase_no == 4);
        repeat (30) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tone_melody_sequencer_tb failed");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_SOUND_ENABLE;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = REQ_TICK;
        in_ch.event_code = '0;
        in_ch.hour_now   = '0;
        in_ch.hour_known = 1'b0;
        out_ch.ready     = 1'b0;
        in_taken         = 1'b0;
        hold_off         = 1'b0;
        queued_cnt       = 0;
        accepted_cnt     = 0;
        mismatch_cnt     = 0;
        phase_no         = 0;
        sound_on         = 1'b1;
        click_on         = 1'b1;
        quiet_from       = '0;
        quiet_to         = '0;
        mel_sel          = '0;
        mel_step         = '0;
        step_ms          = '0;
        playing          = 1'b0;
        click_left       = '0;
        set_idling(34, 88);
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // phase 0: reset values, empty quiet window
        write_reg(CFG_SOUND_ENABLE, 5'd1);
        write_reg(CFG_CLICK_ENABLE, 5'd1);
        write_reg(CFG_QUIET_START, 5'd0);
        write_reg(CFG_QUIET_END, 5'd0);
        push_req(REQ_UNUSED, 3'd7, 5'd31, 1'b1);
        push_req(REQ_PLAY, 3'd5, 5'd12, 1'b1);
        push_req(REQ_PLAY, 3'd7, 5'd0, 1'b0);
        // click while idle, click restart, play during click
        push_req(REQ_CLICK, 3'd0, 5'd0, 1'b0);
        push_req(REQ_TICK, 3'd0, 5'd0, 1'b0);
        push_req(REQ_TICK, 3'd7, 5'd31, 1'b1);
        push_req(REQ_PLAY, 3'd0, 5'd5, 1'b1);
        push_req(REQ_CLICK, 3'd2, 5'd9, 1'b1);
        repeat (8) push_req(REQ_TICK, 3'd0, 5'd0, 1'b0);
        // short melody with a repeated play while it runs
        push_req(REQ_PLAY, 3'd3, 5'd23, 1'b1);
        push_req(REQ_PLAY, 3'd1, 5'd23, 1'b1);
        repeat (9) push_req(REQ_TICK, 3'd4, 5'd16, 1'b0);
        push_random(220);
        drain();

        // phase 1: clicks disabled, plain quiet window
        phase_no = 1;
        write_reg(CFG_CLICK_ENABLE, 5'd0);
        write_reg(CFG_QUIET_START, 5'd8);
        write_reg(CFG_QUIET_END, 5'd20);
        push_req(REQ_CLICK, 3'd0, 5'd0, 1'b0);
        push_req(REQ_PLAY, 3'd2, 5'd31, 1'b1);
        push_random(220);
        drain();

        // phase 2: window wraps past midnight
        phase_no = 2;
        set_idling(88, 34);
        write_reg(CFG_CLICK_ENABLE, 5'd1);
        write_reg(CFG_QUIET_START, 5'd22);
        write_reg(CFG_QUIET_END, 5'd6);
        push_req(REQ_PLAY, 3'd2, 5'd23, 1'b1);
        push_req(REQ_PLAY, 3'd2, 5'd31, 1'b1);
        push_req(REQ_PLAY, 3'd2, 5'd3, 1'b0);
        push_random(220);
        drain();

        // make sure a melody is running before sound is turned off
        while (click_left != 4'd0)
        begin
            repeat (click_left) push_req(REQ_TICK, 3'd0, 5'd0, 1'b0);
            drain();
        end
        push_req(REQ_PLAY, 3'd0, 5'd0, 1'b0);
        drain();

        // phase 3: sound disabled while playing
        phase_no = 3;
        write_reg(CFG_SOUND_ENABLE, 5'd0);
        write_reg(CFG_QUIET_START, 5'd0);
        write_reg(CFG_QUIET_END, 5'd23);
        push_random(220);
        drain();

        // phase 4: one-hour window at the top, no idling, long hold-off
        phase_no = 4;
        set_idling(0, 0);
        write_reg(CFG_SOUND_ENABLE, 5'd1);
        write_reg(CFG_QUIET_START, 5'd23);
        write_reg(CFG_QUIET_END, 5'd0);
        push_random(230);
        drain();

        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0 && status_due.size() == 0)
            $display("tone_melody_sequencer_tb passed");
        else
            $display("tone_melody_sequencer_tb failed");
        $finish;
    end

endmodule
